>>> design/afbd_pkg.sv
// Shared types, codes and coefficient tables for the four-bit ADPCM block decoder.
package afbd_pkg;

    // Command codes passed from the byte front end to the sample back end
    localparam logic [1:0] OP_CLEAR = 2'd0;  // history clear only, no result
    localparam logic [1:0] OP_END   = 2'd1;  // end marker result
    localparam logic [1:0] OP_DATA  = 2'd2;  // two samples from one data byte

    localparam logic [3:0] POS_HEADER    = 4'd0;
    localparam logic [3:0] POS_FLAGS     = 4'd1;
    localparam logic [3:0] POS_LAST_DATA = 4'd15;

    localparam logic [7:0] FLAGS_END  = 8'h07;
    localparam logic [3:0] FILTER_MAX = 4'd4;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic       clr;
        logic [1:0] op;
        logic [7:0] data;
        logic [3:0] shift;
        logic [2:0] filter;
        logic       done;
    } afbd_cmd_t;

    typedef struct packed {
        logic cmd_pending;
        logic second_half;
    } afbd_back_status_t;

    function automatic logic signed [7:0] coef_a(input logic [2:0] filter);
        logic signed [7:0] c;
        case (filter)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [7:0] coef_b(input logic [2:0] filter);
        logic signed [7:0] c;
        case (filter)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

>>> design/afbd_in_if.sv
// Input channel: one stream byte per transfer.
interface afbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart_block;
    logic       clear_history;

    modport source (output valid, output data_byte, output restart_block,
                    output clear_history, input ready);
    modport sink   (input valid, input data_byte, input restart_block,
                    input clear_history, output ready);
endinterface

>>> design/afbd_out_if.sv
// Output channel: one decoded result per transfer.
interface afbd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               end_marker;
    logic               block_done;
    logic               last;

    modport source (output valid, output sample, output end_marker,
                    output block_done, output last, input ready);
    modport sink   (input valid, input sample, input end_marker,
                    input block_done, input last, output ready);
endinterface

>>> design/afbd_front.sv
// Byte front end: tracks block position, header fields and end state, emits commands.
module afbd_front (
    input  logic              clk,
    input  logic              rst_n,
    afbd_in_if.sink           byte_stream,
    input  logic              queue_full,
    output logic              push,
    output afbd_pkg::afbd_cmd_t push_cmd
);
    import afbd_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic [3:0] shift_reg, shift_next;
    logic [2:0] filter_reg, filter_next;
    logic       ended_reg, ended_next;

    logic       accept;
    logic [3:0] pos;
    logic [3:0] hdr_filter;
    logic       want_push;

    assign byte_stream.ready = !queue_full;
    assign accept = byte_stream.valid && !queue_full;
    assign pos = byte_stream.restart_block ? POS_HEADER : pos_reg;
    assign hdr_filter = byte_stream.data_byte[7:4];

    always_comb
    begin
        push_cmd.clr    = byte_stream.clear_history;
        push_cmd.op     = OP_CLEAR;
        push_cmd.data   = byte_stream.data_byte;
        push_cmd.shift  = shift_reg;
        push_cmd.filter = filter_reg;
        push_cmd.done   = (pos == POS_LAST_DATA);
        want_push       = byte_stream.clear_history;
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        filter_next     = filter_reg;
        ended_next      = ended_reg;

        if (pos == POS_HEADER)
        begin
            shift_next  = byte_stream.data_byte[3:0];
            filter_next = (hdr_filter > FILTER_MAX) ? 3'd0 : hdr_filter[2:0];
            ended_next  = 1'b0;
        end
        else if (pos == POS_FLAGS)
        begin
            if (byte_stream.data_byte == FLAGS_END)
            begin
                push_cmd.op = OP_END;
                want_push   = 1'b1;
                ended_next  = 1'b1;
            end
        end
        else if (!ended_reg)
        begin
            push_cmd.op = OP_DATA;
            want_push   = 1'b1;
        end

        // position wraps to the header after the last data byte
        pos_next = pos + 4'd1;
        push     = accept && want_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HEADER;
            shift_reg  <= 4'd0;
            filter_reg <= 3'd0;
            ended_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            filter_reg <= filter_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

>>> design/afbd_cmd_fifo.sv
// Short command queue between the byte front end and the sample back end.
module afbd_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  afbd_pkg::afbd_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output afbd_pkg::afbd_cmd_t head_cmd
);
    import afbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    afbd_cmd_t  slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> design/afbd_back.sv
// Sample back end: prediction history, nibble decode and the output register.
module afbd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  afbd_pkg::afbd_cmd_t       head_cmd,
    output logic                      pop,
    output afbd_pkg::afbd_back_status_t status,
    afbd_out_if.source                sample_stream
);
    import afbd_pkg::*;

    logic signed [15:0] h1_reg, h1_next;
    logic signed [15:0] h2_reg, h2_next;
    logic               phase_reg, phase_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_sample_reg;
    logic               out_end_reg;
    logic               out_done_reg;
    logic               out_last_reg;

    logic               can_emit;
    logic               emit;
    logic signed [15:0] emit_sample;
    logic               emit_end;
    logic               emit_done;
    logic               emit_last;

    logic signed [15:0] h1_eff;
    logic signed [15:0] h2_eff;
    logic [3:0]         nib;
    logic signed [15:0] scaled;
    logic signed [23:0] prod_a;
    logic signed [23:0] prod_b;
    logic signed [24:0] pred_sum;
    logic signed [18:0] pred;
    logic signed [19:0] total;
    logic signed [15:0] sat;

    assign can_emit = !out_valid_reg || sample_stream.ready;

    // clear applies before the first sample of the command
    assign h1_eff = (head_cmd.clr && !phase_reg) ? 16'sd0 : h1_reg;
    assign h2_eff = (head_cmd.clr && !phase_reg) ? 16'sd0 : h2_reg;

    always_comb
    begin
        nib      = phase_reg ? head_cmd.data[7:4] : head_cmd.data[3:0];
        scaled   = $signed({nib, 12'd0}) >>> head_cmd.shift;
        prod_a   = 24'(coef_a(head_cmd.filter)) * 24'(h1_eff);
        prod_b   = 24'(coef_b(head_cmd.filter)) * 24'(h2_eff);
        pred_sum = 25'(prod_a) + 25'(prod_b);
        pred     = 19'(pred_sum >>> 6);
        total    = 20'(scaled) + 20'(pred);
        if (total > 20'(SAMPLE_MAX))
            sat = SAMPLE_MAX;
        else if (total < 20'(SAMPLE_MIN))
            sat = SAMPLE_MIN;
        else
            sat = total[15:0];
    end

    always_comb
    begin
        pop         = 1'b0;
        emit        = 1'b0;
        emit_sample = 16'sd0;
        emit_end    = 1'b0;
        emit_done   = 1'b0;
        emit_last   = 1'b0;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        phase_next  = phase_reg;

        if (head_valid)
        begin
            case (head_cmd.op)
                OP_END:
                begin
                    if (can_emit)
                    begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        emit_end  = 1'b1;
                        emit_last = 1'b1;
                        h1_next   = h1_eff;
                        h2_next   = h2_eff;
                    end
                end
                OP_DATA:
                begin
                    if (can_emit)
                    begin
                        emit        = 1'b1;
                        emit_sample = sat;
                        emit_done   = phase_reg && head_cmd.done;
                        emit_last   = phase_reg;
                        pop         = phase_reg;
                        phase_next  = !phase_reg;
                        h2_next     = h1_eff;
                        h1_next     = sat;
                    end
                end
                default:
                begin
                    // history clear with no result
                    pop     = 1'b1;
                    h1_next = 16'sd0;
                    h2_next = 16'sd0;
                end
            endcase
        end

        out_valid_next = emit ? 1'b1 : (sample_stream.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_reg        <= 16'sd0;
            h2_reg        <= 16'sd0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_sample_reg <= emit_sample;
            out_end_reg    <= emit_end;
            out_done_reg   <= emit_done;
            out_last_reg   <= emit_last;
        end
    end

    assign sample_stream.valid      = out_valid_reg;
    assign sample_stream.sample     = out_sample_reg;
    assign sample_stream.end_marker = out_end_reg;
    assign sample_stream.block_done = out_done_reg;
    assign sample_stream.last       = out_last_reg;

    assign status.cmd_pending = head_valid;
    assign status.second_half = phase_reg;

endmodule

>>> design/adpcm_four_bit_block_decoder_top.sv
// Top level of the four-bit ADPCM block decoder: front end, command queue, back end.
//
//  channel        | modport | moves per transfer
//  ---------------+---------+------------------------------------------------------
//  byte_stream    | sink    | data_byte, restart_block, clear_history
//  sample_stream  | source  | sample, end_marker, block_done, last
//
// The front end takes one byte per cycle while the command queue has room; header,
// ignored flags and bytes after an end marker finish in the front end alone.
// The back end spends one cycle per result while the output register can take one;
// a byte's two samples go in turn: the second sample's prediction needs the first.
// Reset clears position, header fields, history and queue; no clearing pass.
// A stalled sample_stream holds the output register; the queue absorbs up to
// QUEUE_DEPTH commands before byte_stream drops ready.
module adpcm_four_bit_block_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    afbd_in_if.sink     byte_stream,
    afbd_out_if.source  sample_stream
);
    import afbd_pkg::*;

    logic              push;
    afbd_cmd_t         push_cmd;
    logic              queue_full;
    logic              pop;
    logic              head_valid;
    afbd_cmd_t         head_cmd;
    afbd_back_status_t back_status;

    // Classify each byte; only history clears and result-bearing bytes go on.
    afbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Hold commands so either side can stall on its own.
    afbd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Decode samples, advance history, register each result for transfer.
    afbd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .status        (back_status),
        .sample_stream (sample_stream)
    );

`ifndef SYNTHESIS
    // An end-marker result carries a zero sample and closes its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stream.valid && sample_stream.end_marker |->
            sample_stream.sample == 16'sd0 && !sample_stream.block_done &&
            sample_stream.last)
    else $error("end marker result malformed");

    // The last sample of a block is always the second sample of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stream.valid && sample_stream.block_done |->
            sample_stream.last && !sample_stream.end_marker)
    else $error("block_done without last");

    // The second half of a data byte works on a data command still at the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.second_half |->
            back_status.cmd_pending && head_cmd.op == OP_DATA)
    else $error("second sample without a data command");
`endif

endmodule
